// ----- hw/rtl/lds_pkg.sv -----
// ----------------------------------------------------------------------------
// lds_pkg
// shared types and constants for the linear diophantine solver
// ----------------------------------------------------------------------------
package lds_pkg;

  localparam int COEF_BITS_DEF = 32;
  localparam int FIELD_W       = 32;
  localparam int SOL_X_W       = 32;
  localparam int SOL_Y_W       = 64;

  typedef struct packed {
    logic signed [FIELD_W-1:0] coef_a;
    logic signed [FIELD_W-1:0] coef_b;
    logic signed [FIELD_W-1:0] rhs_c;
  } in_beat_t;

  typedef struct packed {
    logic                      solvable;
    logic [SOL_X_W-1:0]        sol_x;
    logic signed [SOL_Y_W-1:0] sol_y;
  } out_beat_t;

endpackage

// ----- hw/rtl/lds_div.sv -----
// ----------------------------------------------------------------------------
// lds_div
// restoring unsigned divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module lds_div
  import lds_pkg::*;
#(
  parameter int DW = 2 * COEF_BITS_DEF,
  parameter int VW = COEF_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  output logic          done,
  output logic [DW-1:0] quo,
  output logic [VW-1:0] rem
);

  localparam int CW = $clog2(DW + 1);

  logic [DW-1:0] quo_r;
  logic [VW-1:0] rem_r;
  logic [VW-1:0] dvs_r;
  logic [CW-1:0] cnt_r;
  logic          run_r;
  logic          done_r;

  logic [VW:0]   trial;
  logic [VW:0]   diff;
  logic          ge;

  assign trial = {rem_r, quo_r[DW-1]};
  assign diff  = trial - {1'b0, dvs_r};
  assign ge    = ~diff[VW];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      // pulse once the last quotient bit has gone in
      done_r <= !start && run_r && (cnt_r == CW'(1));
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= CW'(DW);
      end else if (run_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          run_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (run_r) begin
      quo_r <= {quo_r[DW-2:0], ge};
      rem_r <= ge ? diff[VW-1:0] : trial[VW-1:0];
    end
  end

  assign done = done_r;
  assign quo  = quo_r;
  assign rem  = rem_r;

endmodule

// ----- hw/rtl/linear_diophantine_solver.sv -----
// ----------------------------------------------------------------------------
// linear_diophantine_solver
// solves a*x + b*y = c; for b != 0 gives the solution with the smallest non-negative x
// ----------------------------------------------------------------------------
// The block takes one beat of coefficients at a time and answers with one
// beat: solvable, x and y. Work runs on a single restoring divider that
// yields one quotient bit per cycle, plus a shared multiplier with a
// registered product. The extended Euclid loop needs one division and one
// multiply per step, and up to roughly 1.44*COEF_BITS steps; the tail (gcd
// check, modulus, inverse reduction, x and y) adds six divisions and two
// multiplies. When b is zero only one division is done, and when a and b
// are both zero the answer goes straight to the output stage without any
// division. The input is not taken while an item is in work; a finished
// result waits in the output register while the next item is already
// accepted.
module linear_diophantine_solver
  import lds_pkg::*;
#(
  parameter int COEF_BITS = COEF_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_beat_t  in_beat,
  output logic      out_valid,
  input  logic      out_stall,
  output out_beat_t out_beat
);

  localparam int W   = COEF_BITS;   // magnitude width
  localparam int PW  = 2 * W;       // product / dividend width
  localparam int SW  = W + 1;       // signed coefficient width
  localparam int MPW = 2 * SW;      // multiplier product width

  // sequencer codes
  localparam logic [4:0] ST_IDLE  = 5'd0;
  localparam logic [4:0] ST_DIVGO = 5'd1;
  localparam logic [4:0] ST_DIVW  = 5'd2;
  localparam logic [4:0] ST_MUL   = 5'd3;
  localparam logic [4:0] ST_B0    = 5'd4;
  localparam logic [4:0] ST_EU    = 5'd5;
  localparam logic [4:0] ST_EQ    = 5'd6;
  localparam logic [4:0] ST_ES    = 5'd7;
  localparam logic [4:0] ST_CHK   = 5'd8;
  localparam logic [4:0] ST_M     = 5'd9;
  localparam logic [4:0] ST_SM    = 5'd10;
  localparam logic [4:0] ST_CP    = 5'd11;
  localparam logic [4:0] ST_XP    = 5'd12;
  localparam logic [4:0] ST_XF    = 5'd13;
  localparam logic [4:0] ST_NUM   = 5'd14;
  localparam logic [4:0] ST_Y     = 5'd15;
  localparam logic [4:0] ST_OUT   = 5'd16;

  function automatic logic [W-1:0] mag_w(input logic signed [W-1:0] v);
    return v[W-1] ? (~v + 1'b1) : v;
  endfunction

  logic [4:0] state_r;
  logic [4:0] ret_r;

  // operands of the item, sign taken from the low COEF_BITS bits
  logic signed [W-1:0] a_in, b_in, c_in;
  logic signed [W-1:0] a_r, c_r;
  logic                b_neg_r;
  logic [W-1:0]        ub_r, uc_r;

  // euclid state
  logic [W-1:0]         r0_r, r1_r;
  logic signed [SW-1:0] s0_r, s1_r;

  // tail state
  logic [W-1:0] cq_r, m_r, sm_r, xf_r;
  logic         num_neg_r;

  // shared units
  logic [PW-1:0]         dvd_r;
  logic [W-1:0]          dvs_r;
  logic                  div_done;
  logic [PW-1:0]         div_quo;
  logic [W-1:0]          div_rem;
  logic signed [SW-1:0]  mop_a_r, mop_b_r;
  logic signed [MPW-1:0] mul_r;

  // result
  logic            solv_r;
  logic [31:0]     x_r;
  logic [63:0]     y_r;
  logic            out_valid_r;
  out_beat_t       out_beat_r;

  // combinational helpers
  logic                 neg_ac;
  logic signed [SW-1:0] xs;
  logic signed [63:0]   xw;
  logic [W-1:0]         s0_mag;
  logic signed [PW-1:0] num;
  logic [PW-1:0]        num_mag;
  logic signed [PW-1:0] y_s;
  logic [W-1:0]         rem_neg;

  assign a_in = in_beat.coef_a[W-1:0];
  assign b_in = in_beat.coef_b[W-1:0];
  assign c_in = in_beat.rhs_c[W-1:0];

  assign neg_ac  = a_r[W-1] ^ c_r[W-1];
  assign xs      = neg_ac ? -$signed({1'b0, div_quo[W-1:0]}) : $signed({1'b0, div_quo[W-1:0]});
  assign xw      = 64'(xs);
  assign s0_mag  = s0_r[SW-1] ? W'(-s0_r) : W'(s0_r);
  assign num     = PW'(c_r) - mul_r[PW-1:0];
  assign num_mag = num[PW-1] ? PW'(-num) : PW'(num);
  assign y_s     = (num_neg_r ^ b_neg_r) ? -$signed(div_quo) : $signed(div_quo);
  // m minus remainder, used for wrapping negative residues
  assign rem_neg = m_r - div_rem;

  lds_div #(
    .DW(PW),
    .VW(W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (state_r == ST_DIVGO),
    .dividend (dvd_r),
    .divisor  (dvs_r),
    .done     (div_done),
    .quo      (div_quo),
    .rem      (div_rem)
  );

  // shared multiplier, product always registered
  always_ff @(posedge clk) begin
    mul_r <= mop_a_r * mop_b_r;
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      ret_r       <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      // a new beat is loaded in ST_OUT, a stalled one is held
      out_valid_r <= (state_r == ST_OUT) || (out_valid_r && out_stall);
      case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            if (a_in == '0 && b_in == '0) begin
              state_r <= ST_OUT;
            end else if (b_in == '0) begin
              ret_r   <= ST_B0;
              state_r <= ST_DIVGO;
            end else begin
              state_r <= ST_EU;
            end
          end
        end
        ST_DIVGO: state_r <= ST_DIVW;
        ST_DIVW: begin
          if (div_done) begin
            state_r <= ret_r;
          end
        end
        ST_MUL: state_r <= ret_r;
        ST_B0:  state_r <= ST_OUT;
        ST_EU: begin
          ret_r   <= (r1_r == '0) ? ST_CHK : ST_EQ;
          state_r <= ST_DIVGO;
        end
        ST_EQ: begin
          ret_r   <= ST_ES;
          state_r <= ST_MUL;
        end
        ST_ES: state_r <= ST_EU;
        ST_CHK: begin
          if (div_rem != '0) begin
            state_r <= ST_OUT;
          end else begin
            ret_r   <= ST_M;
            state_r <= ST_DIVGO;
          end
        end
        ST_M: begin
          ret_r   <= ST_SM;
          state_r <= ST_DIVGO;
        end
        ST_SM: begin
          ret_r   <= ST_CP;
          state_r <= ST_DIVGO;
        end
        ST_CP: begin
          ret_r   <= ST_XP;
          state_r <= ST_MUL;
        end
        ST_XP: begin
          ret_r   <= ST_XF;
          state_r <= ST_DIVGO;
        end
        ST_XF: begin
          ret_r   <= ST_NUM;
          state_r <= ST_MUL;
        end
        ST_NUM: begin
          ret_r   <= ST_Y;
          state_r <= ST_DIVGO;
        end
        ST_Y: state_r <= ST_OUT;
        ST_OUT: begin
          // hand over once the output register is free
          if (!out_valid_r || !out_stall) begin
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        a_r     <= a_in;
        c_r     <= c_in;
        b_neg_r <= b_in[W-1];
        ub_r    <= mag_w(b_in);
        uc_r    <= mag_w(c_in);
        r0_r    <= mag_w(a_in);
        r1_r    <= mag_w(b_in);
        s0_r    <= SW'(1);
        s1_r    <= '0;
        solv_r  <= (c_in == '0);
        x_r     <= '0;
        y_r     <= '0;
        // b zero: x = c / a
        dvd_r   <= PW'(mag_w(c_in));
        dvs_r   <= mag_w(a_in);
      end
      ST_B0: begin
        solv_r <= (div_rem == '0);
        x_r    <= (div_rem == '0) ? xw[31:0] : 32'd0;
      end
      ST_EU: begin
        if (r1_r == '0) begin
          // gcd found in r0, test whether it divides c
          dvd_r <= PW'(uc_r);
          dvs_r <= r0_r;
        end else begin
          dvd_r <= PW'(r0_r);
          dvs_r <= r1_r;
        end
      end
      ST_EQ: begin
        r0_r    <= r1_r;
        r1_r    <= div_rem;
        mop_a_r <= $signed({1'b0, div_quo[W-1:0]});
        mop_b_r <= s1_r;
      end
      ST_ES: begin
        s0_r <= s1_r;
        s1_r <= s0_r - mul_r[SW-1:0];
      end
      ST_CHK: begin
        solv_r <= 1'b0;
        cq_r   <= div_quo[W-1:0];
        dvd_r  <= PW'(ub_r);
        dvs_r  <= r0_r;
      end
      ST_M: begin
        m_r   <= div_quo[W-1:0];
        dvd_r <= PW'(s0_mag);
        dvs_r <= div_quo[W-1:0];
      end
      ST_SM: begin
        sm_r  <= (s0_r[SW-1] && div_rem != '0) ? rem_neg : div_rem;
        dvd_r <= PW'(cq_r);
        dvs_r <= m_r;
      end
      ST_CP: begin
        mop_a_r <= $signed({1'b0, sm_r});
        mop_b_r <= $signed({1'b0, div_rem});
      end
      ST_XP: begin
        dvd_r <= mul_r[PW-1:0];
        dvs_r <= m_r;
      end
      ST_XF: begin
        xf_r    <= (neg_ac && div_rem != '0) ? rem_neg : div_rem;
        mop_a_r <= SW'(a_r);
        mop_b_r <= $signed({1'b0, ((neg_ac && div_rem != '0) ? rem_neg : div_rem)});
      end
      ST_NUM: begin
        num_neg_r <= num[PW-1];
        dvd_r     <= num_mag;
        dvs_r     <= ub_r;
      end
      ST_Y: begin
        solv_r <= 1'b1;
        x_r    <= 32'(xf_r);
        y_r    <= 64'(y_s);
      end
      ST_OUT: begin
        if (!out_valid_r || !out_stall) begin
          out_beat_r.solvable <= solv_r;
          out_beat_r.sol_x    <= x_r;
          out_beat_r.sol_y    <= y_r;
        end
      end
      default: begin
      end
    endcase
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_beat  = out_beat_r;

endmodule
